>>> hdl/compacting_item_list_defines.svh
// Assertion macros shared by the list block.
`ifndef COMPACTING_ITEM_LIST_DEFINES_SVH
`define COMPACTING_ITEM_LIST_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define CIL_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Invariant that holds on every rising edge outside reset.
`define CIL_ALWAYS(lbl, cond, msg) \
  `CIL_ASSERT(lbl, 1'b1, cond, msg)

`endif

>>> hdl/cil_pkg.sv
`default_nettype none

package cil_pkg;

  localparam int unsigned FUNC_W     = 3;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned SIZE_W     = 5;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH   = 3'd0,
    FN_POP    = 3'd1,
    FN_POP_AT = 3'd2,
    FN_REMOVE = 3'd3,
    FN_GET    = 3'd4,
    FN_SET    = 3'd5,
    FN_CLEAR  = 3'd6
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

>>> hdl/cil_ram.sv
`default_nettype none

module cil_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> hdl/compacting_item_list.sv
// Push, set, clear, no-op and failed commands go from accept to ST_DONE, pop and get via
// ST_FETCH; ST_DONE loads the output once it is free. Input is taken only in ST_IDLE, so
// a new item waits for the last result; pop-at and remove-value walk the list in ST_SCAN
// through the single RAM read port, one entry per cycle, holding off input meanwhile.
// Reset (async, active low) empties the list and drops any pending result; the entry
// RAM is not cleared, entries are only read below the count.
`default_nettype none

`include "compacting_item_list_defines.svh"

module compacting_item_list #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned ITEM_WIDTH = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // func[2:0], position[6:3], item_value[38:7], zero[39]
  input  wire logic [cil_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // item_out[31:0], status[33:32], size[38:34], zero[39]
  output logic      [cil_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > cil_pkg::POS_W) ? CW : cil_pkg::POS_W;

  cil_pkg::state_e  state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    rd_idx_q, rd_idx_d;
  logic [CW-1:0]    kept_q, kept_d;
  logic             pend_q, pend_d;
  logic             hit_q, hit_d;
  logic             is_rm_q, is_rm_d;
  logic             out_valid_q, out_valid_d;

  logic [ITEM_WIDTH-1:0]           val_q, val_d;
  logic [cil_pkg::VAL_W-1:0]       res_item_q, res_item_d;
  cil_pkg::status_e                res_stat_q, res_stat_d;
  logic [cil_pkg::VAL_W-1:0]       out_item_q, out_item_d;
  cil_pkg::status_e                out_stat_q, out_stat_d;
  logic [cil_pkg::SIZE_W-1:0]      out_size_q, out_size_d;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [ITEM_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [ITEM_WIDTH-1:0] ram_rdata;

  cil_pkg::func_e        in_func;
  logic [PW-1:0]         in_pos;
  logic [ITEM_WIDTH-1:0] in_val;
  logic                  in_acc;
  logic                  pos_ok;
  logic                  is_full;
  logic                  is_empty;
  logic [CW-1:0]         cnt_m1;
  logic                  drop;

  assign in_func  = cil_pkg::func_e'(s_axis_tdata[2:0]);
  assign in_pos   = PW'(s_axis_tdata[6:3]);
  assign in_val   = ITEM_WIDTH'(s_axis_tdata[38:7]);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign pos_ok   = in_pos < PW'(count_q);
  assign is_full  = count_q == CW'(DEPTH);
  assign is_empty = count_q == '0;
  assign cnt_m1   = count_q - CW'(1);

  // pop-at drops the first entry it reads; remove-value drops every match
  assign drop = is_rm_q ? (ram_rdata == val_q) : !hit_q;

  assign s_axis_tready = state_q == cil_pkg::ST_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_size_q, out_stat_q, out_item_q};

  cil_ram #(
    .WIDTH (ITEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    kept_d      = kept_q;
    pend_d      = pend_q;
    hit_d       = hit_q;
    is_rm_d     = is_rm_q;
    out_valid_d = out_valid_q;
    val_d       = val_q;
    res_item_d  = res_item_q;
    res_stat_d  = res_stat_q;
    out_item_d  = out_item_q;
    out_stat_d  = out_stat_q;
    out_size_d  = out_size_q;
    ram_we      = 1'b0;
    ram_waddr   = kept_q[AW-1:0];
    ram_wdata   = ram_rdata;
    ram_raddr   = rd_idx_q[AW-1:0];

    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      cil_pkg::ST_IDLE: begin
        if (in_acc) begin
          val_d      = in_val;
          res_item_d = '0;
          res_stat_d = cil_pkg::STAT_OK;
          state_d    = cil_pkg::ST_DONE;
          case (in_func)
            cil_pkg::FN_PUSH: begin
              if (is_full) begin
                res_stat_d = cil_pkg::STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_q[AW-1:0];
                ram_wdata = in_val;
                count_d   = count_q + CW'(1);
              end
            end
            cil_pkg::FN_POP: begin
              if (is_empty) begin
                res_stat_d = cil_pkg::STAT_EMPTY;
              end else begin
                ram_raddr = cnt_m1[AW-1:0];
                count_d   = cnt_m1;
                state_d   = cil_pkg::ST_FETCH;
              end
            end
            cil_pkg::FN_POP_AT: begin
              if (is_empty) begin
                res_stat_d = cil_pkg::STAT_EMPTY;
              end else if (!pos_ok) begin
                res_stat_d = cil_pkg::STAT_RANGE;
              end else begin
                rd_idx_d = in_pos[CW-1:0];
                kept_d   = in_pos[CW-1:0];
                pend_d   = 1'b0;
                hit_d    = 1'b0;
                is_rm_d  = 1'b0;
                state_d  = cil_pkg::ST_SCAN;
              end
            end
            cil_pkg::FN_REMOVE: begin
              rd_idx_d = '0;
              kept_d   = '0;
              pend_d   = 1'b0;
              hit_d    = 1'b0;
              is_rm_d  = 1'b1;
              state_d  = cil_pkg::ST_SCAN;
            end
            cil_pkg::FN_GET: begin
              if (!pos_ok) begin
                res_stat_d = cil_pkg::STAT_RANGE;
              end else begin
                ram_raddr = in_pos[AW-1:0];
                state_d   = cil_pkg::ST_FETCH;
              end
            end
            cil_pkg::FN_SET: begin
              if (!pos_ok) begin
                res_stat_d = cil_pkg::STAT_RANGE;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = in_pos[AW-1:0];
                ram_wdata = in_val;
              end
            end
            cil_pkg::FN_CLEAR: begin
              count_d = '0;
            end
            default: ;
          endcase
        end
      end
      cil_pkg::ST_FETCH: begin
        res_item_d = 32'(ram_rdata);
        state_d    = cil_pkg::ST_DONE;
      end
      cil_pkg::ST_SCAN: begin
        // reader runs at least one entry ahead of the writer; writes land at or behind it
        pend_d = 1'b0;
        if (rd_idx_q != count_q) begin
          rd_idx_d = rd_idx_q + CW'(1);
          pend_d   = 1'b1;
        end
        if (pend_q) begin
          if (drop) begin
            if (!is_rm_q) begin
              res_item_d = 32'(ram_rdata);
              hit_d      = 1'b1;
            end
          end else begin
            ram_we = 1'b1;
            kept_d = kept_q + CW'(1);
          end
        end else if (rd_idx_q == count_q) begin
          count_d = kept_q;
          state_d = cil_pkg::ST_DONE;
        end
      end
      cil_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_item_d  = res_item_q;
          out_stat_d  = res_stat_q;
          out_size_d  = cil_pkg::SIZE_W'(count_q);
          state_d     = cil_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cil_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cil_pkg::ST_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      kept_q      <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      is_rm_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      kept_q      <= kept_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      is_rm_q     <= is_rm_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    res_item_q <= res_item_d;
    res_stat_q <= res_stat_d;
    out_item_q <= out_item_d;
    out_stat_q <= out_stat_d;
    out_size_q <= out_size_d;
  end

  `CIL_ALWAYS(a_count_bound, count_q <= CW'(DEPTH), "item count above depth")
  `CIL_ASSERT(a_writer_behind, state_q == cil_pkg::ST_SCAN, kept_q <= rd_idx_q, "writer ahead")
  `CIL_ASSERT(a_result_from_done, $rose(out_valid_q), $past(state_q == cil_pkg::ST_DONE), "stray")

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned FUNC_W     = cil_pkg::FUNC_W;
  localparam int unsigned POS_W      = cil_pkg::POS_W;
  localparam int unsigned VAL_W      = cil_pkg::VAL_W;
  localparam int unsigned STAT_W     = cil_pkg::STAT_W;
  localparam int unsigned SIZE_W     = cil_pkg::SIZE_W;
  localparam int unsigned IN_DATA_W  = cil_pkg::IN_DATA_W;
  localparam int unsigned OUT_DATA_W = cil_pkg::OUT_DATA_W;

  localparam logic [FUNC_W-1:0] FN_NOP = 3'd7;  // unused code, answers like a no-op
  localparam int unsigned LIST_DEPTH      = 16;
  localparam int unsigned TARGET_ITEMS    = 1050;
  localparam int unsigned PRESSURE_AT     = 300;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES    = 40;
  localparam int unsigned MAX_CYCLES      = 400000;
  localparam int unsigned REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [VAL_W-1:0]  item;
    cil_pkg::status_e  status;
    logic [SIZE_W-1:0] size;
  } list_result_t;

  typedef enum int {SEQ_FILL, SEQ_DRAIN, SEQ_MIXED, SEQ_NOISE} seq_kind_e;

  class item_list_model;
    logic [VAL_W-1:0] entries [LIST_DEPTH];
    int unsigned      count;
    int unsigned      peak_count;
    list_result_t     pending [$];
    int unsigned      checked;
    int unsigned      mismatches;
    int unsigned      func_seen [8];
    int unsigned      status_seen [4];

    function void take_command(logic [IN_DATA_W-1:0] data);
      logic [FUNC_W-1:0] func;
      logic [POS_W-1:0]  pos;
      logic [VAL_W-1:0]  val;
      list_result_t      res;
      int unsigned       i;
      int unsigned       kept;
      func = data[2:0];
      pos = data[6:3];
      val = data[38:7];
      res.item = '0;
      res.status = cil_pkg::STAT_OK;
      case (func)
        cil_pkg::FN_PUSH: begin
          if (count >= LIST_DEPTH) begin
            res.status = cil_pkg::STAT_FULL;
          end else begin
            entries[count] = val;
            count++;
          end
        end
        cil_pkg::FN_POP: begin
          if (count == 0) begin
            res.status = cil_pkg::STAT_EMPTY;
          end else begin
            count--;
            res.item = entries[count];
          end
        end
        cil_pkg::FN_POP_AT: begin
          if (count == 0) begin
            res.status = cil_pkg::STAT_EMPTY;
          end else if (pos >= count) begin
            res.status = cil_pkg::STAT_RANGE;
          end else begin
            res.item = entries[pos];
            for (i = pos; i + 1 < count; i++) entries[i] = entries[i + 1];
            count--;
          end
        end
        cil_pkg::FN_REMOVE: begin
          kept = 0;
          for (i = 0; i < count; i++) begin
            if (entries[i] != val) begin
              entries[kept] = entries[i];
              kept++;
            end
          end
          count = kept;
        end
        cil_pkg::FN_GET: begin
          if (pos >= count) res.status = cil_pkg::STAT_RANGE;
          else res.item = entries[pos];
        end
        cil_pkg::FN_SET: begin
          if (pos >= count) res.status = cil_pkg::STAT_RANGE;
          else entries[pos] = val;
        end
        cil_pkg::FN_CLEAR: count = 0;
        default: ;
      endcase
      res.size = count[SIZE_W-1:0];
      if (count > peak_count) peak_count = count;
      func_seen[func]++;
      status_seen[res.status]++;
      pending.push_back(res);
    endfunction

    function void match_result(logic [OUT_DATA_W-1:0] data);
      list_result_t      want;
      logic [VAL_W-1:0]  item;
      logic [STAT_W-1:0] status;
      logic [SIZE_W-1:0] size;
      item = data[31:0];
      status = data[33:32];
      size = data[38:34];
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: item %h status %0d size %0d", item, status, size);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (item !== want.item || status !== want.status || size !== want.size) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result %0d mismatch: expected item %h status %0d size %0d, got %h %0d %0d",
                   checked, want.item, want.status, want.size, item, status, size);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  wire                   s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  wire                   m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  wire  [OUT_DATA_W-1:0] m_axis_tdata;

  item_list_model   model;
  int unsigned      items_sent = 0;
  int unsigned      cycle_count = 0;
  logic             pressure_req = 1'b0;
  logic             pressure_done = 1'b0;
  logic [VAL_W-1:0] value_pool [4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001};

  compacting_item_list uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               model.pending.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Results first: anything leaving at this edge belongs to an earlier item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) model.match_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) model.take_command(s_axis_tdata);
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_command(logic [FUNC_W-1:0] func,
                                                       logic [POS_W-1:0] pos,
                                                       logic [VAL_W-1:0] val);
    return {1'b0, val, pos, func};
  endfunction

  // Biased toward live positions and values already in the list.
  function automatic logic [IN_DATA_W-1:0] make_command(seq_kind_e kind);
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  val;
    int unsigned       roll;
    roll = $urandom_range(0, 99);
    case (kind)
      SEQ_FILL: begin
        if (roll < 70) func = cil_pkg::FN_PUSH;
        else if (roll < 80) func = cil_pkg::FN_GET;
        else if (roll < 90) func = cil_pkg::FN_SET;
        else if (roll < 95) func = cil_pkg::FN_REMOVE;
        else func = cil_pkg::FN_POP;
      end
      SEQ_DRAIN: begin
        if (roll < 40) func = cil_pkg::FN_POP;
        else if (roll < 70) func = cil_pkg::FN_POP_AT;
        else if (roll < 88) func = cil_pkg::FN_REMOVE;
        else if (roll < 96) func = cil_pkg::FN_GET;
        else func = cil_pkg::FN_PUSH;
      end
      SEQ_MIXED: begin
        if (roll < 3) func = cil_pkg::FN_CLEAR;
        else if (roll < 5) func = FN_NOP;
        else func = FUNC_W'($urandom_range(0, 5));
      end
      default: func = FUNC_W'($urandom_range(0, 7));
    endcase
    if (kind != SEQ_NOISE && model.count > 0 && $urandom_range(0, 99) < 80)
      pos = POS_W'($urandom_range(0, model.count - 1));
    else
      pos = POS_W'($urandom_range(0, 15));
    roll = $urandom_range(0, 99);
    if (roll < 45 || kind == SEQ_NOISE) val = $urandom;
    else if (roll < 65 || model.count == 0) val = value_pool[$urandom_range(0, 3)];
    else val = model.entries[$urandom_range(0, model.count - 1)];
    return pack_command(func, pos, val);
  endfunction

  // Caller starts at a falling edge; returns at the accepting rising edge.
  task automatic offer(input logic [IN_DATA_W-1:0] data);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic issue(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] pos,
                       input logic [VAL_W-1:0] val);
    @(negedge clk_i);
    offer(pack_command(func, pos, val));
  endtask

  task automatic idle(input int unsigned cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  // Receiver: stall pattern changes between random modes, plus one long hold-off.
  initial begin
    int unsigned mode_left;
    int unsigned ready_pct;
    mode_left = 0;
    ready_pct = 100;
    forever begin
      @(negedge clk_i);
      if (pressure_req && !pressure_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk_i);
        pressure_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(20, 200);
          case ($urandom_range(0, 3))
            0: ready_pct = 100;
            1: ready_pct = 70;
            2: ready_pct = 40;
            default: ready_pct = 15;
          endcase
        end
        mode_left--;
        m_axis_tready <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  initial begin
    int unsigned burst_left;
    int unsigned seq_left;
    int unsigned roll;
    seq_kind_e   kind;
    model = new;
    burst_left = 0;
    seq_left = 0;
    kind = SEQ_FILL;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty list corner cases
    issue(cil_pkg::FN_POP, 4'd0, 32'h0);
    issue(cil_pkg::FN_POP_AT, 4'd15, 32'h0);
    issue(cil_pkg::FN_GET, 4'd0, 32'h0);
    issue(cil_pkg::FN_SET, 4'd15, 32'hFFFF_FFFF);
    issue(cil_pkg::FN_REMOVE, 4'd0, 32'h0);
    issue(cil_pkg::FN_CLEAR, 4'd0, 32'h0);
    issue(FN_NOP, 4'd15, 32'hFFFF_FFFF);
    // small list: bounds, set, pop-at, multi-match removal
    issue(cil_pkg::FN_PUSH, 4'd0, 32'h0000_0000);
    issue(cil_pkg::FN_PUSH, 4'd0, 32'hFFFF_FFFF);
    issue(cil_pkg::FN_PUSH, 4'd0, 32'hA5A5_A5A5);
    issue(cil_pkg::FN_PUSH, 4'd0, 32'h0000_0000);
    issue(cil_pkg::FN_GET, 4'd0, 32'h0);
    issue(cil_pkg::FN_GET, 4'd3, 32'h0);
    issue(cil_pkg::FN_GET, 4'd4, 32'h0);
    issue(cil_pkg::FN_SET, 4'd1, 32'h5A5A_5A5A);
    issue(cil_pkg::FN_GET, 4'd1, 32'h0);
    issue(cil_pkg::FN_POP_AT, 4'd15, 32'h0);
    issue(cil_pkg::FN_POP_AT, 4'd1, 32'h0);
    issue(cil_pkg::FN_REMOVE, 4'd0, 32'h1234_5678);
    issue(cil_pkg::FN_REMOVE, 4'd0, 32'h0000_0000);
    issue(cil_pkg::FN_POP, 4'd0, 32'h0);
    issue(cil_pkg::FN_PUSH, 4'd0, 32'h7FFF_FFFF);
    issue(cil_pkg::FN_CLEAR, 4'd0, 32'h0);
    issue(cil_pkg::FN_POP, 4'd0, 32'h0);

    while (items_sent < TARGET_ITEMS) begin
      if (seq_left == 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 35) kind = SEQ_FILL;
        else if (roll < 60) kind = SEQ_DRAIN;
        else if (roll < 90) kind = SEQ_MIXED;
        else kind = SEQ_NOISE;
        seq_left = $urandom_range(4, 30);
      end
      if (burst_left == 0) begin
        if ($urandom_range(0, 99) >= 30) idle($urandom_range(1, 8));
        burst_left = $urandom_range(1, 40);
      end
      // back-to-back items while the receiver is held off
      if (!pressure_req && items_sent >= PRESSURE_AT) begin
        pressure_req = 1'b1;
        burst_left = 60;
      end
      @(negedge clk_i);
      offer(make_command(kind));
      seq_left--;
      burst_left--;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (model.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d items sent, %0d results checked; push %0d pop %0d pop-at %0d remove %0d",
             items_sent, model.checked, model.func_seen[cil_pkg::FN_PUSH],
             model.func_seen[cil_pkg::FN_POP], model.func_seen[cil_pkg::FN_POP_AT],
             model.func_seen[cil_pkg::FN_REMOVE]);
    $display("get %0d set %0d clear %0d unused %0d; ok %0d empty %0d range %0d full %0d; peak %0d",
             model.func_seen[cil_pkg::FN_GET], model.func_seen[cil_pkg::FN_SET],
             model.func_seen[cil_pkg::FN_CLEAR], model.func_seen[FN_NOP],
             model.status_seen[cil_pkg::STAT_OK], model.status_seen[cil_pkg::STAT_EMPTY],
             model.status_seen[cil_pkg::STAT_RANGE], model.status_seen[cil_pkg::STAT_FULL],
             model.peak_count);
    if (model.mismatches == 0 && model.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", model.mismatches, model.pending.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/cil_pkg.sv
hdl/cil_ram.sv
hdl/compacting_item_list.sv
tb/tb_top.sv
